FILE: rtl/c2p_pkg.sv
// c2p_pkg: shared constants, types and the arctangent table for cartesian_to_polar
// no dependencies; used by c2p_stage, cartesian_to_polar, c2p_checker and tb
package c2p_pkg;

    localparam int COORD_WIDTH_DEF   = 24;
    localparam int CORDIC_STAGES_DEF = 24;

    localparam int GUARD_BITS = 8;
    localparam int MAG_WIDTH  = 24;
    localparam int ANG_WIDTH  = 25;
    // angle accumulator, wide enough for +-(90 + sum of table) degrees in q16
    localparam int ZW         = 26;

    localparam logic [31:0]          GAIN_COMP = 32'h9B74_EDA8;
    localparam logic signed [ZW-1:0] DEG90     = ZW'(5898240);
    localparam logic signed [ZW-1:0] DEG180    = ZW'(11796480);

    typedef enum logic [2:0] {
        ANG_CORDIC = 3'd0,
        ANG_ZERO   = 3'd1,
        ANG_POS90  = 3'd2,
        ANG_NEG90  = 3'd3,
        ANG_POS180 = 3'd4
    } ang_sel_t;

    typedef struct packed {
        logic     zero;
        ang_sel_t sel;
    } c2p_side_t;

    // atan(2^-i) in degrees, q16, rounded to nearest
    function automatic logic signed [ZW-1:0] c2p_atan(input logic [4:0] idx);
        logic signed [ZW-1:0] v;
        case (idx)
            5'd0:    v = ZW'(2949120);
            5'd1:    v = ZW'(1740967);
            5'd2:    v = ZW'(919879);
            5'd3:    v = ZW'(466945);
            5'd4:    v = ZW'(234379);
            5'd5:    v = ZW'(117304);
            5'd6:    v = ZW'(58666);
            5'd7:    v = ZW'(29335);
            5'd8:    v = ZW'(14668);
            5'd9:    v = ZW'(7334);
            5'd10:   v = ZW'(3667);
            5'd11:   v = ZW'(1833);
            5'd12:   v = ZW'(917);
            5'd13:   v = ZW'(458);
            5'd14:   v = ZW'(229);
            5'd15:   v = ZW'(115);
            5'd16:   v = ZW'(57);
            5'd17:   v = ZW'(29);
            5'd18:   v = ZW'(14);
            5'd19:   v = ZW'(7);
            5'd20:   v = ZW'(4);
            5'd21:   v = ZW'(2);
            5'd22:   v = ZW'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

FILE: rtl/c2p_stage.sv
// c2p_stage: one registered cordic vectoring micro-rotation with valid/ready
// depends on c2p_pkg
module c2p_stage
    import c2p_pkg::*;
#(
    parameter int XW  = 34,
    parameter int IDX = 0
)(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic signed [XW-1:0] x_in,
    input  logic signed [XW-1:0] y_in,
    input  logic signed [ZW-1:0] z_in,
    input  c2p_side_t            side_in,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic signed [XW-1:0] x_out,
    output logic signed [XW-1:0] y_out,
    output logic signed [ZW-1:0] z_out,
    output c2p_side_t            side_out
);

    localparam logic signed [ZW-1:0] ATAN = c2p_atan(5'(IDX));

    logic                 valid_reg;
    logic signed [XW-1:0] x_reg, x_next;
    logic signed [XW-1:0] y_reg, y_next;
    logic signed [ZW-1:0] z_reg, z_next;
    c2p_side_t            side_reg;
    logic signed [XW-1:0] xs, ys;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        xs = x_in >>> IDX;
        ys = y_in >>> IDX;
        if (!y_in[XW-1])
        begin
            x_next = x_in + ys;
            y_next = y_in - xs;
            z_next = z_in + ATAN;
        end
        else
        begin
            x_next = x_in - ys;
            y_next = y_in + xs;
            z_next = z_in - ATAN;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            z_reg    <= z_next;
            side_reg <= side_in;
        end
    end

    assign out_valid = valid_reg;
    assign x_out     = x_reg;
    assign y_out     = y_reg;
    assign z_out     = z_reg;
    assign side_out  = side_reg;

endmodule

FILE: rtl/cartesian_to_polar.sv
// cartesian_to_polar: pipelined cordic conversion of (x, y) to magnitude and angle
// depends on c2p_pkg and c2p_stage
//
// usage:
//   input channel: in_valid/in_ready with x_coord, y_coord (signed, COORD_WIDTH bits)
//   output channel: out_valid/out_ready with magnitude (24 bits, same scale as the
//   inputs), angle_deg (signed q9.16 degrees, -180 .. +180) and zero_vector
//   pipeline: one quadrant fold stage, one register per cordic micro-rotation,
//   one gain multiply stage and one round and saturate stage
//   throughput: one beat per cycle while out_ready stays high; every stage holds
//   one beat and has its own valid bit, so a stage takes a new beat whenever it is
//   empty or passes its beat on
//   receiver stall: the output beat holds; beats behind it close up any empty
//   stages, then in_ready falls; nothing is dropped or repeated
//   reset: all valid bits clear, the pipeline is empty and in_ready is high
//   zero vector: magnitude 0, angle 0, zero_vector 1
module cartesian_to_polar
    import c2p_pkg::*;
#(
    parameter int COORD_WIDTH   = COORD_WIDTH_DEF,
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
)(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [COORD_WIDTH-1:0] x_coord,
    input  logic signed [COORD_WIDTH-1:0] y_coord,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic        [MAG_WIDTH-1:0]   magnitude,
    output logic signed [ANG_WIDTH-1:0]   angle_deg,
    output logic                          zero_vector
);

    localparam int XW = COORD_WIDTH + GUARD_BITS + 2;
    localparam int HW = XW - 16;
    localparam int TW = HW + 32 + 1;
    localparam int N  = CORDIC_STAGES;

    // quadrant fold
    logic                 v0_reg;
    logic signed [XW-1:0] x0_reg, x0_next;
    logic signed [XW-1:0] y0_reg, y0_next;
    logic signed [ZW-1:0] z0_reg, z0_next;
    c2p_side_t            s0_reg, s0_next;
    logic signed [XW-1:0] xe, ye;
    logic                 rdy0;

    always_comb
    begin
        xe = XW'(x_coord);
        ye = XW'(y_coord);
        if (x_coord[COORD_WIDTH-1])
        begin
            if (!y_coord[COORD_WIDTH-1])
            begin
                x0_next = ye <<< GUARD_BITS;
                y0_next = (-xe) <<< GUARD_BITS;
                z0_next = DEG90;
            end
            else
            begin
                x0_next = (-ye) <<< GUARD_BITS;
                y0_next = xe <<< GUARD_BITS;
                z0_next = -DEG90;
            end
        end
        else
        begin
            x0_next = xe <<< GUARD_BITS;
            y0_next = ye <<< GUARD_BITS;
            z0_next = '0;
        end

        s0_next.zero = (x_coord == '0) && (y_coord == '0);
        if (y_coord == '0)
            s0_next.sel = x_coord[COORD_WIDTH-1] ? ANG_POS180 : ANG_ZERO;
        else if (x_coord == '0)
            s0_next.sel = y_coord[COORD_WIDTH-1] ? ANG_NEG90 : ANG_POS90;
        else
            s0_next.sel = ANG_CORDIC;
    end

    // micro-rotation chain
    logic                 cv [0:N];
    logic                 cr [0:N];
    logic signed [XW-1:0] cx [0:N];
    logic signed [XW-1:0] cy [0:N];
    logic signed [ZW-1:0] cz [0:N];
    c2p_side_t            cs [0:N];

    assign rdy0     = !v0_reg || cr[0];
    assign in_ready = rdy0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
        end
        else if (rdy0)
        begin
            v0_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy0 && in_valid)
        begin
            x0_reg <= x0_next;
            y0_reg <= y0_next;
            z0_reg <= z0_next;
            s0_reg <= s0_next;
        end
    end

    assign cv[0] = v0_reg;
    assign cx[0] = x0_reg;
    assign cy[0] = y0_reg;
    assign cz[0] = z0_reg;
    assign cs[0] = s0_reg;

    for (genvar i = 0; i < N; i++)
    begin : g_stage
        c2p_stage #(
            .XW  (XW),
            .IDX (i)
        ) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (cv[i]),
            .in_ready  (cr[i]),
            .x_in      (cx[i]),
            .y_in      (cy[i]),
            .z_in      (cz[i]),
            .side_in   (cs[i]),
            .out_valid (cv[i+1]),
            .out_ready (cr[i+1]),
            .x_out     (cx[i+1]),
            .y_out     (cy[i+1]),
            .z_out     (cz[i+1]),
            .side_out  (cs[i+1])
        );
    end

    // gain multiply and angle select
    logic                        vm_reg;
    logic [HW+31:0]              phi_reg;
    logic [31:0]                 plo_reg;
    logic signed [ANG_WIDTH-1:0] ang_reg, ang_next;
    logic                        zm_reg;
    logic [XW-1:0]               mag;
    logic [47:0]                 lo_prod;
    logic signed [ZW-1:0]        zsat;
    logic                        rdy_mul;
    logic                        rdy_fin;

    assign rdy_mul   = !vm_reg || rdy_fin;
    assign cr[N]     = rdy_mul;
    assign mag       = cx[N][XW-1] ? '0 : cx[N];
    assign lo_prod   = mag[15:0] * GAIN_COMP;

    always_comb
    begin
        if (cz[N] > DEG180)
            zsat = DEG180;
        else if (cz[N] < -DEG180)
            zsat = -DEG180;
        else
            zsat = cz[N];

        unique case (cs[N].sel)
            ANG_CORDIC: ang_next = zsat[ANG_WIDTH-1:0];
            ANG_ZERO:   ang_next = '0;
            ANG_POS90:  ang_next = DEG90[ANG_WIDTH-1:0];
            ANG_NEG90:  ang_next = ANG_WIDTH'(-DEG90);
            ANG_POS180: ang_next = DEG180[ANG_WIDTH-1:0];
            default:    ang_next = '0;
        endcase
        if (cs[N].zero)
            ang_next = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vm_reg <= 1'b0;
        end
        else if (rdy_mul)
        begin
            vm_reg <= cv[N];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy_mul && cv[N])
        begin
            phi_reg <= mag[XW-1:16] * GAIN_COMP;
            plo_reg <= lo_prod[47:16];
            ang_reg <= ang_next;
            zm_reg  <= cs[N].zero;
        end
    end

    // round and saturate
    logic                        vf_reg;
    logic [MAG_WIDTH-1:0]        mag_reg, mag_next;
    logic signed [ANG_WIDTH-1:0] angf_reg;
    logic                        zf_reg;
    logic [TW-1:0]               tsum;

    assign rdy_fin = !vf_reg || out_ready;

    always_comb
    begin
        tsum = TW'(phi_reg) + TW'(plo_reg) + TW'(24'h80_0000);
        if (tsum[TW-1:24] > (TW-24)'({MAG_WIDTH{1'b1}}))
            mag_next = {MAG_WIDTH{1'b1}};
        else
            mag_next = tsum[24 +: MAG_WIDTH];
        if (zm_reg)
            mag_next = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vf_reg <= 1'b0;
        end
        else if (rdy_fin)
        begin
            vf_reg <= vm_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy_fin && vm_reg)
        begin
            mag_reg  <= mag_next;
            angf_reg <= ang_reg;
            zf_reg   <= zm_reg;
        end
    end

    assign out_valid   = vf_reg;
    assign magnitude   = mag_reg;
    assign angle_deg   = angf_reg;
    assign zero_vector = zf_reg;

endmodule

FILE: verif/c2p_checker.sv
// c2p_checker: watches both channels of cartesian_to_polar, predicts each result
// beat with its own cordic vectoring model and compares it field by field
// depends on c2p_pkg for the field widths
module c2p_checker
    import c2p_pkg::*;
#(
    parameter int COORD_WIDTH   = COORD_WIDTH_DEF,
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
)(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_ready,
    input  logic signed [COORD_WIDTH-1:0] x_coord,
    input  logic signed [COORD_WIDTH-1:0] y_coord,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic        [MAG_WIDTH-1:0]   magnitude,
    input  logic signed [ANG_WIDTH-1:0]   angle_deg,
    input  logic                          zero_vector,
    output int                            fail_count,
    output int                            pending
);

    localparam int              GUARD_SHIFT  = 8;
    localparam int              ATAN_ENTRIES = 32;
    localparam longint          Q16_ONE      = 65536;
    localparam longint          QUARTER_TURN = 90 * Q16_ONE;
    localparam longint          HALF_TURN    = 180 * Q16_ONE;
    localparam longint unsigned GAIN_Q32     = 64'h9B74_EDA8;
    localparam longint unsigned MAG_CEIL     = (64'd1 << MAG_WIDTH) - 64'd1;
    localparam int              ROTATIONS    =
        (CORDIC_STAGES > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STAGES;

    // atan(2^-k) in degrees, q16, rounded to nearest
    localparam longint ATAN_Q16 [0:ATAN_ENTRIES-1] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0,
        0, 0, 0, 0, 0, 0, 0, 0
    };

    typedef struct packed {
        logic [MAG_WIDTH-1:0] mag;
        logic [ANG_WIDTH-1:0] ang;
        logic                 zero;
    } polar_t;

    polar_t polar_q[$];
    polar_t want;
    int     result_beats;

    function automatic polar_t to_polar(input logic signed [COORD_WIDTH-1:0] xc,
                                        input logic signed [COORD_WIDTH-1:0] yc);
        longint          xi, yi, xr, yr, zacc, xs, ys, nx;
        longint unsigned mag, hi, lo, scaled;
        polar_t          res;
        int              k;
        xi  = xc;
        yi  = yc;
        res = '0;
        if (xi == 0 && yi == 0)
        begin
            res.zero = 1'b1;
            return res;
        end
        // fold the left half-plane into the right one
        if (xi < 0)
        begin
            if (yi >= 0)
            begin
                xr   = yi;
                yr   = -xi;
                zacc = QUARTER_TURN;
            end
            else
            begin
                xr   = -yi;
                yr   = xi;
                zacc = -QUARTER_TURN;
            end
        end
        else
        begin
            xr   = xi;
            yr   = yi;
            zacc = 0;
        end
        xr = xr * (64'sd1 << GUARD_SHIFT);
        yr = yr * (64'sd1 << GUARD_SHIFT);
        for (k = 0; k < ROTATIONS; k++)
        begin
            xs = xr >>> k;
            ys = yr >>> k;
            if (yr >= 0)
            begin
                nx   = xr + ys;
                yr   = yr - xs;
                zacc = zacc + ATAN_Q16[k];
            end
            else
            begin
                nx   = xr - ys;
                yr   = yr + xs;
                zacc = zacc - ATAN_Q16[k];
            end
            xr = nx;
        end
        if (zacc > HALF_TURN)
            zacc = HALF_TURN;
        if (zacc < -HALF_TURN)
            zacc = -HALF_TURN;
        if (xi == 0)
            zacc = (yi > 0) ? QUARTER_TURN : -QUARTER_TURN;
        if (yi == 0)
            zacc = (xi > 0) ? 0 : HALF_TURN;
        // gain compensation, rounded to nearest, guard bits dropped
        mag    = (xr < 0) ? 64'd0 : longint'(unsigned'(xr));
        hi     = mag >> 16;
        lo     = mag & 64'hFFFF;
        scaled = hi * GAIN_Q32 + ((lo * GAIN_Q32) >> 16);
        scaled = (scaled + (64'd1 << (15 + GUARD_SHIFT))) >> (16 + GUARD_SHIFT);
        if (scaled > MAG_CEIL)
            scaled = MAG_CEIL;
        res.mag = scaled[MAG_WIDTH-1:0];
        res.ang = zacc[ANG_WIDTH-1:0];
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at result beat %0d: %s", result_beats, msg);
        fail_count++;
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            fail_count   = 0;
            result_beats = 0;
            pending      <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (polar_q.size() == 0)
                    report_mismatch($sformatf("no beat expected, got mag %0d angle %0d zero %0b",
                                              magnitude, angle_deg, zero_vector));
                else
                begin
                    want = polar_q.pop_front();
                    if (magnitude !== want.mag)
                        report_mismatch($sformatf("magnitude %0d, expected %0d",
                                                  magnitude, want.mag));
                    if (angle_deg !== want.ang)
                        report_mismatch($sformatf("angle_deg %0d, expected %0d",
                                                  angle_deg, $signed(want.ang)));
                    if (zero_vector !== want.zero)
                        report_mismatch($sformatf("zero_vector %0b, expected %0b",
                                                  zero_vector, want.zero));
                end
                result_beats++;
            end
            if (in_valid && in_ready)
                polar_q.push_back(to_polar(x_coord, y_coord));
            pending <= polar_q.size();
        end
    end

endmodule

FILE: verif/tb.sv
// tb: drives cartesian_to_polar with directed and random coordinate beats under
// random idling on both channels, c2p_checker predicts and compares the results
// depends on c2p_pkg, cartesian_to_polar and c2p_checker
module tb;
    import c2p_pkg::*;

    localparam int CW          = COORD_WIDTH_DEF;
    localparam int RANDOM_BEATS = 550;
    localparam int TAIL_BEATS  = 100;
    localparam int HOLD_CYCLES = 200;
    localparam int QUIET_LIMIT = 4000;
    localparam int DRAIN_WAIT  = CORDIC_STAGES_DEF + 3 + 10;

    localparam logic signed [CW-1:0] COORD_MIN = {1'b1, {(CW-1){1'b0}}};
    localparam logic signed [CW-1:0] COORD_MAX = {1'b0, {(CW-1){1'b1}}};

    logic                        clk;
    logic                        rst_n;
    logic                        in_valid;
    logic                        in_ready;
    logic signed [CW-1:0]        x_coord;
    logic signed [CW-1:0]        y_coord;
    logic                        out_valid;
    logic                        out_ready;
    logic        [MAG_WIDTH-1:0] magnitude;
    logic signed [ANG_WIDTH-1:0] angle_deg;
    logic                        zero_vector;

    int fail_count;
    int pending;
    int quiet_cycles = 0;
    bit tail_phase   = 1'b0;
    bit hold_req     = 1'b0;

    cartesian_to_polar uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .x_coord     (x_coord),
        .y_coord     (y_coord),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .magnitude   (magnitude),
        .angle_deg   (angle_deg),
        .zero_vector (zero_vector)
    );

    c2p_checker #(
        .COORD_WIDTH   (CW),
        .CORDIC_STAGES (CORDIC_STAGES_DEF)
    ) polar_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .x_coord     (x_coord),
        .y_coord     (y_coord),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .magnitude   (magnitude),
        .angle_deg   (angle_deg),
        .zero_vector (zero_vector),
        .fail_count  (fail_count),
        .pending     (pending)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == QUIET_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic logic signed [CW-1:0] corner_coord(input int sel);
        case (sel)
            0:       return COORD_MIN;
            1:       return '1;
            2:       return '0;
            3:       return CW'(1);
            default: return COORD_MAX;
        endcase
    endfunction

    // one beat on the input channel, then maybe a gap
    task automatic send_pair(input logic signed [CW-1:0] xv, input logic signed [CW-1:0] yv);
        in_valid <= 1'b1;
        x_coord  <= xv;
        y_coord  <= yv;
        do @(posedge clk); while (!in_ready);
        if (!tail_phase && $urandom_range(0, 2) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
    endtask

    // receiver side
    initial
    begin
        bit held_off;
        held_off  = 1'b0;
        out_ready = 1'b0;
        wait (rst_n);
        forever
        begin
            if (hold_req && !held_off)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                held_off = 1'b1;
            end
            else if (!tail_phase && $urandom_range(0, 3) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
        end
    end

    // sender side and verdict
    initial
    begin
        logic signed [CW-1:0] xv;
        logic signed [CW-1:0] yv;
        rst_n    = 1'b0;
        in_valid = 1'b0;
        x_coord  = '0;
        y_coord  = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // zero vector, axes, extremes, near +-180
        send_pair('0, '0);
        send_pair(COORD_MAX, '0);
        send_pair(COORD_MIN, '0);
        send_pair('0, COORD_MAX);
        send_pair('0, COORD_MIN);
        send_pair(CW'(1), '0);
        send_pair('1, '0);
        send_pair('0, CW'(1));
        send_pair('0, '1);
        send_pair(COORD_MAX, COORD_MAX);
        send_pair(COORD_MIN, COORD_MIN);
        send_pair(COORD_MAX, COORD_MIN);
        send_pair(COORD_MIN, COORD_MAX);
        send_pair(CW'(1), CW'(1));
        send_pair('1, '1);
        send_pair('1, CW'(1));
        send_pair(CW'(1), '1);
        send_pair(COORD_MIN, '1);
        send_pair(COORD_MIN, CW'(1));
        send_pair(COORD_MAX, '1);
        send_pair('1, COORD_MIN);
        send_pair(24'sh555555, -24'sh2AAAAA);

        hold_req <= 1'b1;
        for (int k = 0; k < RANDOM_BEATS; k++)
        begin
            if (k == RANDOM_BEATS - TAIL_BEATS)
                tail_phase <= 1'b1;
            case ($urandom_range(0, 11))
                0:
                begin
                    xv = CW'(int'($urandom_range(0, 32)) - 16);
                    yv = CW'(int'($urandom_range(0, 32)) - 16);
                end
                1:
                begin
                    xv = '0;
                    yv = CW'($urandom());
                end
                2:
                begin
                    xv = CW'($urandom());
                    yv = '0;
                end
                3:
                begin
                    xv = corner_coord($urandom_range(0, 4));
                    yv = corner_coord($urandom_range(0, 4));
                end
                4:
                begin
                    xv = CW'($urandom());
                    yv = CW'(int'($urandom_range(0, 6)) - 3);
                end
                5:
                begin
                    xv = CW'($urandom()) | COORD_MIN;
                    yv = CW'(int'($urandom_range(0, 64)) - 32);
                end
                default:
                begin
                    xv = CW'($urandom());
                    yv = CW'($urandom());
                end
            endcase
            send_pair(xv, yv);
        end
        in_valid <= 1'b0;

        do @(posedge clk); while (pending != 0);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
